// ===== hdl/cubic_bezier_solve_y_for_x_defines.svh =====
// Assertion helpers for the checked module, cbs_ctrl.
// Each expects clk and rst_n in scope.
`ifndef CUBIC_BEZIER_SOLVE_Y_FOR_X_DEFINES_SVH
`define CUBIC_BEZIER_SOLVE_Y_FOR_X_DEFINES_SVH

// same-cycle implication
`define CBS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CBS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/cbs_pkg.sv =====
package cbs_pkg;

    localparam int MAX_ITER = 24;
    localparam int COORD_W  = 24;
    localparam int T_BITS   = 16;
    localparam int TOL_W    = 16;

    // t and 1-t carry one extra bit so that 1.0 fits
    localparam int T_W    = T_BITS + 1;
    // weights with the factor 3 applied
    localparam int W_W    = T_BITS + 2;
    localparam int MA_W   = COORD_W + 1;
    localparam int MB_W   = W_W + 1;
    localparam int PROD_W = MA_W + MB_W;
    localparam int ACC_W  = PROD_W + 2;
    localparam int SH_W   = ACC_W - T_BITS;
    localparam int ERR_W  = COORD_W + 1;
    localparam int ITER_W = $clog2(MAX_ITER + 1);

    localparam logic [TOL_W-1:0]        TOL_RESET = TOL_W'(655);
    localparam logic [T_W-1:0]          T_ONE     = T_W'(1) << T_BITS;
    localparam logic [PROD_W-1:0]       PROD_HALF = PROD_W'(1) << (T_BITS - 1);
    localparam logic signed [ACC_W-1:0] ACC_HALF  = ACC_W'(1) << (T_BITS - 1);
    localparam logic signed [SH_W-1:0]  SH_MAX    = (SH_W'(1) << (COORD_W - 1)) - SH_W'(1);
    localparam logic signed [SH_W-1:0]  SH_MIN    = -SH_MAX - SH_W'(1);

    // one evaluation: six weight products, eight coordinate products, two drain steps
    typedef enum logic [3:0] {
        ST_SS  = 4'd0,
        ST_TT  = 4'd1,
        ST_W0  = 4'd2,
        ST_W1  = 4'd3,
        ST_W2  = 4'd4,
        ST_W3  = 4'd5,
        ST_X0  = 4'd6,
        ST_X1  = 4'd7,
        ST_X2  = 4'd8,
        ST_X3  = 4'd9,
        ST_Y0  = 4'd10,
        ST_Y1  = 4'd11,
        ST_Y2  = 4'd12,
        ST_Y3  = 4'd13,
        ST_ACC = 4'd14,
        ST_FIN = 4'd15
    } step_t;

    typedef struct packed {
        logic           busy;
        logic           issue;
        logic           fin_fire;
        step_t          step;
        logic [T_W-1:0] mid;
    } ctrl_t;

    typedef struct packed {
        logic met;
        logic err_pos;
        logic out_free;
    } judge_t;

    typedef struct packed {
        logic  vld;
        step_t tag;
    } mtag_t;

endpackage

// ===== hdl/cbs_mul.sv =====
module cbs_mul
    import cbs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  step_t                    tag,
    input  logic signed [MA_W-1:0]   a,
    input  logic signed [MB_W-1:0]   b,
    output logic signed [PROD_W-1:0] prod,
    output mtag_t                    res
);

    logic signed [PROD_W-1:0] prod_reg;
    mtag_t                    res_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= a * b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg <= '0;
        end
        else
        begin
            res_reg.vld <= en;
            res_reg.tag <= tag;
        end
    end

    assign prod = prod_reg;
    assign res  = res_reg;

endmodule

// ===== hdl/cbs_ctrl.sv =====
`include "cubic_bezier_solve_y_for_x_defines.svh"

module cbs_ctrl
    import cbs_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_fire,
    input  judge_t judge,
    output ctrl_t  ctrl
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    step_t             step_reg, step_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic [T_W-1:0]    left_reg, left_next;
    logic [T_W-1:0]    right_reg, right_next;
    logic [T_W-1:0]    mid;
    logic              last_iter;
    logic              at_fin;
    logic              done;

    assign mid       = left_reg + ((right_reg - left_reg) >> 1);
    assign last_iter = (iter_reg == ITER_W'(MAX_ITER - 1));
    assign at_fin    = (state_reg == S_RUN) && (step_reg == ST_FIN);
    assign done      = judge.met || last_iter;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        iter_next  = iter_reg;
        left_next  = left_reg;
        right_next = right_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_RUN;
                    step_next  = ST_SS;
                    iter_next  = '0;
                    left_next  = '0;
                    right_next = T_ONE;
                end
            end
            S_RUN:
            begin
                if (step_reg != ST_FIN)
                begin
                    step_next = step_t'(step_reg + 4'd1);
                end
                else if (done)
                begin
                    // hold the final step until the output register is free
                    if (judge.out_free)
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    step_next = ST_SS;
                    iter_next = iter_reg + 1'b1;
                    if (judge.err_pos)
                    begin
                        left_next = mid;
                    end
                    else
                    begin
                        right_next = mid;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= ST_SS;
            iter_reg  <= '0;
            left_reg  <= '0;
            right_reg <= T_ONE;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            iter_reg  <= iter_next;
            left_reg  <= left_next;
            right_reg <= right_next;
        end
    end

    assign ctrl.busy     = (state_reg == S_RUN);
    assign ctrl.issue    = (state_reg == S_RUN) && (step_reg <= ST_Y3);
    assign ctrl.fin_fire = at_fin && done && judge.out_free;
    assign ctrl.step     = step_reg;
    assign ctrl.mid      = mid;

    // bounds may meet once they were adjacent and the error was not positive
    `CBS_ASSERT_NXT(a_start, state_reg == S_IDLE && in_fire,
        state_reg == S_RUN && step_reg == ST_SS && iter_reg == '0, "bad start of request")
    `CBS_ASSERT_IMP(a_bounds, state_reg == S_RUN, left_reg <= right_reg,
        "bisection bounds crossed")
    `CBS_ASSERT_IMP(a_iter_cap, state_reg == S_RUN, iter_reg <= ITER_W'(MAX_ITER - 1),
        "iteration count past cap")
    `CBS_ASSERT_NXT(a_advance, at_fin && !done,
        step_reg == ST_SS && iter_reg == $past(iter_reg) + 1'b1, "iteration did not advance")
    `CBS_ASSERT_NXT(a_finish, ctrl.fin_fire, state_reg == S_IDLE,
        "still busy after result load")

endmodule

// ===== hdl/cubic_bezier_solve_y_for_x.sv =====
// channel  | handshake            | payload
// ---------+----------------------+----------------------------------------------
// in       | in_valid / in_ready  | target_x, start_*, ctrl1_*, ctrl2_*, end_*
// out      | out_valid / out_ready| point_x, point_y, param_t, gave_up
// cfg      | cfg_valid / cfg_ready| cfg_data (tolerance)
//
// One evaluation runs 14 products through the single shared 25x19 multiplier
// plus two drain/decide steps. A request runs n = 1..24 evaluations from
// accept to out_valid; in_ready rises together with out_valid.
// Reset is asynchronous; tolerance returns to 655.
// A result waits in the output register while the next request runs; if it is
// still untaken when that request finishes, the final step holds.
module cubic_bezier_solve_y_for_x
    import cbs_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [COORD_W-1:0] target_x,
    input  logic signed [COORD_W-1:0] start_x,
    input  logic signed [COORD_W-1:0] start_y,
    input  logic signed [COORD_W-1:0] ctrl1_x,
    input  logic signed [COORD_W-1:0] ctrl1_y,
    input  logic signed [COORD_W-1:0] ctrl2_x,
    input  logic signed [COORD_W-1:0] ctrl2_y,
    input  logic signed [COORD_W-1:0] end_x,
    input  logic signed [COORD_W-1:0] end_y,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [COORD_W-1:0] point_x,
    output logic signed [COORD_W-1:0] point_y,
    output logic [T_BITS-1:0]         param_t,
    output logic                      gave_up,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [TOL_W-1:0]          cfg_data
);

    ctrl_t  ctrl;
    judge_t judge;
    mtag_t  mres;
    logic   in_fire;

    logic [TOL_W-1:0]          tol_reg;
    logic signed [COORD_W-1:0] target_reg;
    logic signed [COORD_W-1:0] px_reg [0:3];
    logic signed [COORD_W-1:0] py_reg [0:3];
    logic [T_W-1:0]            s2_reg, t2_reg;
    logic [W_W-1:0]            w_reg [0:3];
    logic signed [ACC_W-1:0]   accx_reg, accy_reg;

    logic                      out_valid_reg;
    logic signed [COORD_W-1:0] point_x_reg, point_y_reg;
    logic [T_BITS-1:0]         param_t_reg;
    logic                      gave_up_reg;

    logic [T_W-1:0]            s_val;
    logic signed [MA_W-1:0]    mul_a;
    logic signed [MB_W-1:0]    mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic [PROD_W-1:0]         prod_rnd_sum;
    logic [T_W-1:0]            prod_rnd;
    logic [W_W-1:0]            prod_rnd3;
    logic signed [ACC_W-1:0]   prod_ext;
    logic signed [COORD_W-1:0] cx, cy;
    logic signed [ERR_W-1:0]   err;
    logic [ERR_W-1:0]          mag;

    function automatic logic signed [COORD_W-1:0] coord_round(
        input logic signed [ACC_W-1:0] acc
    );
        logic signed [ACC_W-1:0] sum;
        logic signed [SH_W-1:0]  sh;
        sum = acc + ACC_HALF;
        sh  = sum[ACC_W-1:T_BITS];
        if (sh > SH_MAX)
        begin
            sh = SH_MAX;
        end
        else if (sh < SH_MIN)
        begin
            sh = SH_MIN;
        end
        return sh[COORD_W-1:0];
    endfunction

    assign in_ready  = !ctrl.busy;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    cbs_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_fire (in_fire),
        .judge   (judge),
        .ctrl    (ctrl)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            tol_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            target_reg <= target_x;
            px_reg[0]  <= start_x;
            py_reg[0]  <= start_y;
            px_reg[1]  <= ctrl1_x;
            py_reg[1]  <= ctrl1_y;
            px_reg[2]  <= ctrl2_x;
            py_reg[2]  <= ctrl2_y;
            px_reg[3]  <= end_x;
            py_reg[3]  <= end_y;
        end
    end

    // operand select for the shared multiplier
    assign s_val = T_ONE - ctrl.mid;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (ctrl.step)
            ST_SS:
            begin
                mul_a = {{(MA_W-T_W){1'b0}}, s_val};
                mul_b = {{(MB_W-T_W){1'b0}}, s_val};
            end
            ST_TT:
            begin
                mul_a = {{(MA_W-T_W){1'b0}}, ctrl.mid};
                mul_b = {{(MB_W-T_W){1'b0}}, ctrl.mid};
            end
            ST_W0:
            begin
                mul_a = {{(MA_W-T_W){1'b0}}, s2_reg};
                mul_b = {{(MB_W-T_W){1'b0}}, s_val};
            end
            ST_W1:
            begin
                mul_a = {{(MA_W-T_W){1'b0}}, s2_reg};
                mul_b = {{(MB_W-T_W){1'b0}}, ctrl.mid};
            end
            ST_W2:
            begin
                mul_a = {{(MA_W-T_W){1'b0}}, t2_reg};
                mul_b = {{(MB_W-T_W){1'b0}}, s_val};
            end
            ST_W3:
            begin
                mul_a = {{(MA_W-T_W){1'b0}}, t2_reg};
                mul_b = {{(MB_W-T_W){1'b0}}, ctrl.mid};
            end
            ST_X0:
            begin
                mul_a = {px_reg[0][COORD_W-1], px_reg[0]};
                mul_b = {1'b0, w_reg[0]};
            end
            ST_X1:
            begin
                mul_a = {px_reg[1][COORD_W-1], px_reg[1]};
                mul_b = {1'b0, w_reg[1]};
            end
            ST_X2:
            begin
                mul_a = {px_reg[2][COORD_W-1], px_reg[2]};
                mul_b = {1'b0, w_reg[2]};
            end
            ST_X3:
            begin
                mul_a = {px_reg[3][COORD_W-1], px_reg[3]};
                mul_b = {1'b0, w_reg[3]};
            end
            ST_Y0:
            begin
                mul_a = {py_reg[0][COORD_W-1], py_reg[0]};
                mul_b = {1'b0, w_reg[0]};
            end
            ST_Y1:
            begin
                mul_a = {py_reg[1][COORD_W-1], py_reg[1]};
                mul_b = {1'b0, w_reg[1]};
            end
            ST_Y2:
            begin
                mul_a = {py_reg[2][COORD_W-1], py_reg[2]};
                mul_b = {1'b0, w_reg[2]};
            end
            ST_Y3:
            begin
                mul_a = {py_reg[3][COORD_W-1], py_reg[3]};
                mul_b = {1'b0, w_reg[3]};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    cbs_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (ctrl.issue),
        .tag   (ctrl.step),
        .a     (mul_a),
        .b     (mul_b),
        .prod  (prod),
        .res   (mres)
    );

    // round half up for the weight products (always non-negative)
    assign prod_rnd_sum = prod + PROD_HALF;
    assign prod_rnd     = prod_rnd_sum[T_BITS +: T_W];
    assign prod_rnd3    = W_W'(prod_rnd) + (W_W'(prod_rnd) << 1);
    assign prod_ext     = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};

    // write-back in the cycle after issue
    always_ff @(posedge clk)
    begin
        if (mres.vld)
        begin
            case (mres.tag)
                ST_SS:   s2_reg   <= prod_rnd;
                ST_TT:   t2_reg   <= prod_rnd;
                ST_W0:   w_reg[0] <= W_W'(prod_rnd);
                ST_W1:   w_reg[1] <= prod_rnd3;
                ST_W2:   w_reg[2] <= prod_rnd3;
                ST_W3:   w_reg[3] <= W_W'(prod_rnd);
                ST_X0:   accx_reg <= prod_ext;
                ST_X1, ST_X2, ST_X3:
                         accx_reg <= accx_reg + prod_ext;
                ST_Y0:   accy_reg <= prod_ext;
                ST_Y1, ST_Y2, ST_Y3:
                         accy_reg <= accy_reg + prod_ext;
                default: ;
            endcase
        end
    end

    assign cx  = coord_round(accx_reg);
    assign cy  = coord_round(accy_reg);
    assign err = {target_reg[COORD_W-1], target_reg} - {cx[COORD_W-1], cx};
    assign mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);

    assign judge.met      = (mag <= ERR_W'(tol_reg));
    assign judge.err_pos  = !err[ERR_W-1] && (err != '0);
    assign judge.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.fin_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.fin_fire)
        begin
            point_x_reg <= cx;
            point_y_reg <= cy;
            param_t_reg <= ctrl.mid[T_BITS-1:0];
            gave_up_reg <= !judge.met;
        end
    end

    assign out_valid = out_valid_reg;
    assign point_x   = point_x_reg;
    assign point_y   = point_y_reg;
    assign param_t   = param_t_reg;
    assign gave_up   = gave_up_reg;

endmodule
